>>> hdl/maze_backtracker_step_assert.svh
// Assertion macros for the maze carver. Each macro takes a label, a property
// expression and a message. The first form is switched off while reset is
// asserted; the second form is checked on every clock edge, reset included.
`ifndef MAZE_BACKTRACKER_STEP_ASSERT_SVH
`define MAZE_BACKTRACKER_STEP_ASSERT_SVH

`ifndef SYNTHESIS
`define MBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MBS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MBS_ASSERT(label, prop, msg)
`define MBS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> hdl/mbs_pkg.sv
package mbs_pkg;

  // Grid capacity. Coordinates travel in fixed 6-bit fields.
  localparam int unsigned MAX_ROWS   = 64;
  localparam int unsigned MAX_COLS   = 64;
  localparam int unsigned CELL_COUNT = MAX_ROWS * MAX_COLS;
  localparam int unsigned CELL_W     = $clog2(CELL_COUNT);
  localparam int unsigned CNT_W      = $clog2(CELL_COUNT + 1);

  localparam int unsigned COORD_W    = 6;
  localparam int unsigned GRID_W     = 7;
  localparam int unsigned STACK_W    = 2 * COORD_W;
  localparam int unsigned PICK_W     = 8;
  localparam int unsigned NBR        = 4;
  localparam int unsigned NBR_W      = $clog2(NBR);
  localparam int unsigned SCAN_W     = $clog2(NBR + 1);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = GRID_W;
  localparam int unsigned M_DATA_W   = 40;
  localparam int unsigned M_USER_W   = 2;

  localparam logic [GRID_W-1:0] ROWS_RST = GRID_W'(64);
  localparam logic [GRID_W-1:0] COLS_RST = GRID_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS      = 2'd0,
    REG_COLS      = 2'd1,
    REG_START_ROW = 2'd2,
    REG_START_COL = 2'd3
  } cfg_reg_e;

  // Neighbour order: bit 1 picks the column, bit 0 picks the +1 direction.
  typedef enum logic [NBR_W-1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CLEAR  = 7'b0000010,
    ST_START  = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_DECIDE = 7'b0010000,
    ST_POP    = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic               carved;
    logic               finished;
    logic [COORD_W-1:0] from_row;
    logic [COORD_W-1:0] from_col;
    logic [COORD_W-1:0] to_row;
    logic [COORD_W-1:0] to_col;
    logic [COORD_W-1:0] current_row;
    logic [COORD_W-1:0] current_col;
  } result_t;

  function automatic logic [CELL_W-1:0] cell_idx(input logic [COORD_W-1:0] row,
                                                 input logic [COORD_W-1:0] col);
    int unsigned lin;
    lin = int'(row) * MAX_COLS + int'(col);
    return CELL_W'(lin % CELL_COUNT);
  endfunction

  // Remainder by three: base-four digits each weigh one modulo three.
  function automatic logic [1:0] mod3(input logic [PICK_W-1:0] val);
    logic [3:0] dsum;
    logic [2:0] fold;
    logic [2:0] res;
    dsum = 4'(val[1:0]) + 4'(val[3:2]) + 4'(val[5:4]) + 4'(val[7:6]);
    fold = 3'(dsum[1:0]) + 3'(dsum[3:2]);
    if (fold >= 3'd6) begin
      res = fold - 3'd6;
    end else if (fold >= 3'd3) begin
      res = fold - 3'd3;
    end else begin
      res = fold;
    end
    return res[1:0];
  endfunction

endpackage

>>> hdl/maze_backtracker_step.sv
// Randomised depth-first maze carver. Each input beat either restarts the walk
// (tuser high) or takes one carving step, and every beat yields exactly one
// result beat. A step reads the four neighbours of the current cell from the
// visited memory one at a time through a single neighbour-address unit, then
// decides in the decide state whether to carve, backtrack or report finished. A
// backtrack also passes through the pop state, as the popped cell comes from
// the stack memory's registered read port; s_axis_tready rises in the same
// cycle as the result is placed. The visited memory has a single write port,
// so a restart clears it one cell a cycle, then marks the start cell and
// places its result. After reset the same clearing pass runs, during which
// s_axis_tready stays low; configuration writes are taken at any time. Grid
// sizes of zero act as one and sizes above the capacity act as the capacity; a
// start cell outside the grid saturates to the last row or column. Any result
// may wait in the output register while the next beat is accepted and worked
// on; should it still be waiting when the next result is ready, the sequencer
// holds that result until the register is taken, and s_axis_tready stays low
// for as long.
`include "maze_backtracker_step_assert.svh"

module maze_backtracker_step (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Register write port.
  input  logic                             cfg_we_i,
  input  logic [mbs_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [mbs_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // Command stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mbs_pkg::PICK_W-1:0]       s_axis_tdata,  // [7:0] random_pick
  input  logic                             s_axis_tuser,  // [0] restart
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [5:0] from_row, [11:6] from_col, [17:12] to_row, [23:18] to_col,
  // [29:24] current_row, [35:30] current_col, [39:36] zero
  output logic [mbs_pkg::M_DATA_W-1:0]     m_axis_tdata,
  output logic [mbs_pkg::M_USER_W-1:0]     m_axis_tuser   // [0] carved, [1] finished
);

  import mbs_pkg::*;

  // Configuration registers.
  logic [GRID_W-1:0]  rows_q, cols_q;
  logic [COORD_W-1:0] start_row_q, start_col_q;

  // Sequencer and walk state.
  state_e              state_q, state_d;
  logic [CELL_W-1:0]   clr_addr_q, clr_addr_d;
  logic                clr_restart_q, clr_restart_d;
  logic [SCAN_W-1:0]   scan_q, scan_d;
  logic [NBR-1:0]      nb_ok_q, nb_ok_d;
  logic [COORD_W-1:0]  nb_row_q [NBR];
  logic [COORD_W-1:0]  nb_col_q [NBR];
  logic [NBR-1:0]      cand_q, cand_d;
  logic [PICK_W-1:0]   pick_q, pick_d;
  logic [COORD_W-1:0]  cur_row_q, cur_row_d, cur_col_q, cur_col_d;
  logic [CNT_W-1:0]    count_q, count_d;
  result_t             res_q, res_d;
  result_t             out_q, out_d;
  logic                out_valid_q, out_valid_d;

  // Memories.
  logic                vis_mem [CELL_COUNT];
  logic                vis_we, vis_wdata, vis_re, vis_rdata_q;
  logic [CELL_W-1:0]   vis_waddr, vis_raddr;
  logic [STACK_W-1:0]  stk_mem [CELL_COUNT];
  logic                stk_we, stk_re;
  logic [CELL_W-1:0]   stk_waddr, stk_raddr;
  logic [STACK_W-1:0]  stk_wdata, stk_rdata_q;

  // Grid limits after saturation.
  logic [GRID_W-1:0]   grid_rows, grid_cols;
  logic [COORD_W-1:0]  sat_row, sat_col;

  // Shared neighbour unit.
  logic [NBR_W-1:0]    nb_dir;
  logic [GRID_W-1:0]   nb_operand, nb_sum, nb_row, nb_col;
  logic                nb_under, nb_in_grid;

  // Decision logic.
  logic [2:0]          cand_cnt;
  logic [NBR_W-1:0]    pick_sel, chosen;
  logic [NBR_W-1:0]    prev_k;
  logic                s_accept;

  always_comb begin
    if (rows_q == '0) begin
      grid_rows = GRID_W'(1);
    end else if (rows_q > GRID_W'(MAX_ROWS)) begin
      grid_rows = GRID_W'(MAX_ROWS);
    end else begin
      grid_rows = rows_q;
    end
    if (cols_q == '0) begin
      grid_cols = GRID_W'(1);
    end else if (cols_q > GRID_W'(MAX_COLS)) begin
      grid_cols = GRID_W'(MAX_COLS);
    end else begin
      grid_cols = cols_q;
    end
  end

  // The start cell saturates to the last row and column of the grid.
  assign sat_row = ({1'b0, start_row_q} < grid_rows) ? start_row_q
                                                     : COORD_W'(grid_rows - GRID_W'(1));
  assign sat_col = ({1'b0, start_col_q} < grid_cols) ? start_col_q
                                                     : COORD_W'(grid_cols - GRID_W'(1));

  // One adder moves the current cell by one row or column; the result is in
  // the grid only when it did not run below zero and lies under both limits.
  assign nb_dir     = scan_q[NBR_W-1:0];
  assign nb_operand = nb_dir[1] ? {1'b0, cur_col_q} : {1'b0, cur_row_q};
  assign nb_sum     = nb_operand + (nb_dir[0] ? GRID_W'(1) : {GRID_W{1'b1}});
  assign nb_under   = !nb_dir[0] && (nb_operand == '0);
  assign nb_row     = nb_dir[1] ? {1'b0, cur_row_q} : nb_sum;
  assign nb_col     = nb_dir[1] ? nb_sum : {1'b0, cur_col_q};
  assign nb_in_grid = !nb_under && (nb_row < grid_rows) && (nb_col < grid_cols);

  // Data read during scan step k belongs to the neighbour issued in the step
  // before; the two-bit wrap also maps the final scan step onto the last one.
  assign prev_k = scan_q[NBR_W-1:0] - NBR_W'(1);

  assign cand_cnt = 3'($countones(cand_q));

  always_comb begin
    case (cand_cnt)
      3'd2:    pick_sel = NBR_W'(pick_q[0]);
      3'd3:    pick_sel = mod3(pick_q);
      3'd4:    pick_sel = pick_q[1:0];
      default: pick_sel = '0;
    endcase
  end

  // Walk the free neighbours in order and keep the one whose rank matches.
  always_comb begin
    logic [2:0] seen;
    seen   = '0;
    chosen = '0;
    for (int k = 0; k < NBR; k++) begin
      if (cand_q[k]) begin
        if (seen == 3'(pick_sel)) begin
          chosen = NBR_W'(k);
        end
        seen = seen + 3'd1;
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d       = state_q;
    clr_addr_d    = clr_addr_q;
    clr_restart_d = clr_restart_q;
    scan_d        = scan_q;
    nb_ok_d       = nb_ok_q;
    cand_d        = cand_q;
    pick_d        = pick_q;
    cur_row_d     = cur_row_q;
    cur_col_d     = cur_col_q;
    count_d       = count_q;
    res_d         = res_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q;

    vis_we    = 1'b0;
    vis_waddr = clr_addr_q;
    vis_wdata = 1'b0;
    vis_re    = 1'b0;
    vis_raddr = cell_idx(nb_row[COORD_W-1:0], nb_col[COORD_W-1:0]);
    stk_we    = 1'b0;
    stk_waddr = count_q[CELL_W-1:0];
    stk_wdata = '0;
    stk_re    = 1'b0;
    stk_raddr = CELL_W'(count_q - CNT_W'(1));

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          pick_d = s_axis_tdata;
          if (s_axis_tuser) begin
            clr_addr_d    = '0;
            clr_restart_d = 1'b1;
            state_d       = ST_CLEAR;
          end else begin
            scan_d  = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_CLEAR: begin
        vis_we     = 1'b1;
        clr_addr_d = clr_addr_q + CELL_W'(1);
        if (clr_addr_q == CELL_W'(CELL_COUNT - 1)) begin
          state_d = clr_restart_q ? ST_START : ST_IDLE;
        end
      end
      ST_START: begin
        vis_we    = 1'b1;
        vis_waddr = cell_idx(sat_row, sat_col);
        vis_wdata = 1'b1;
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = {sat_row, sat_col};
        count_d   = CNT_W'(1);
        cur_row_d = sat_row;
        cur_col_d = sat_col;
        res_d     = '0;
        state_d   = ST_EMIT;
      end
      ST_SCAN: begin
        if (scan_q != SCAN_W'(NBR)) begin
          vis_re          = 1'b1;
          nb_ok_d[nb_dir] = nb_in_grid;
        end
        if (scan_q != '0) begin
          cand_d[prev_k] = nb_ok_q[prev_k] && !vis_rdata_q;
        end
        scan_d = scan_q + SCAN_W'(1);
        if (scan_q == SCAN_W'(NBR)) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        res_d = '0;
        if (cand_q == '0) begin
          if (count_q == '0) begin
            res_d.finished = 1'b1;
            state_d        = ST_EMIT;
          end else begin
            stk_re  = 1'b1;
            count_d = count_q - CNT_W'(1);
            state_d = ST_POP;
          end
        end else begin
          vis_we         = 1'b1;
          vis_waddr      = cell_idx(nb_row_q[chosen], nb_col_q[chosen]);
          vis_wdata      = 1'b1;
          if (count_q < CNT_W'(CELL_COUNT)) begin
            stk_we  = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
          stk_wdata      = {nb_row_q[chosen], nb_col_q[chosen]};
          res_d.carved   = 1'b1;
          res_d.from_row = cur_row_q;
          res_d.from_col = cur_col_q;
          res_d.to_row   = nb_row_q[chosen];
          res_d.to_col   = nb_col_q[chosen];
          cur_row_d      = nb_row_q[chosen];
          cur_col_d      = nb_col_q[chosen];
          state_d        = ST_EMIT;
        end
      end
      ST_POP: begin
        cur_row_d = stk_rdata_q[STACK_W-1:COORD_W];
        cur_col_d = stk_rdata_q[COORD_W-1:0];
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d             = res_q;
          out_d.current_row = cur_row_q;
          out_d.current_col = cur_col_q;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q      <= ROWS_RST;
      cols_q      <= COLS_RST;
      start_row_q <= '0;
      start_col_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_ROWS:      rows_q      <= cfg_wdata_i;
        REG_COLS:      cols_q      <= cfg_wdata_i;
        REG_START_ROW: start_row_q <= cfg_wdata_i[COORD_W-1:0];
        REG_START_COL: start_col_q <= cfg_wdata_i[COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control state. Reset starts the clearing pass of the visited memory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_addr_q    <= '0;
      clr_restart_q <= 1'b0;
      scan_q        <= '0;
      count_q       <= '0;
      cur_row_q     <= '0;
      cur_col_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_addr_q    <= clr_addr_d;
      clr_restart_q <= clr_restart_d;
      scan_q        <= scan_d;
      count_q       <= count_d;
      cur_row_q     <= cur_row_d;
      cur_col_q     <= cur_col_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    nb_ok_q <= nb_ok_d;
    cand_q  <= cand_d;
    pick_q  <= pick_d;
    res_q   <= res_d;
    out_q   <= out_d;
    if (vis_re) begin
      nb_row_q[nb_dir] <= nb_row[COORD_W-1:0];
      nb_col_q[nb_dir] <= nb_col[COORD_W-1:0];
    end
  end

  // Visited memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    if (vis_re) begin
      vis_rdata_q <= vis_mem[vis_raddr];
    end
  end

  // Path stack: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_q <= stk_mem[stk_raddr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.current_col, out_q.current_row,
                          out_q.to_col, out_q.to_row, out_q.from_col, out_q.from_row};
  assign m_axis_tuser  = {out_q.finished, out_q.carved};

  // A restart beat always begins with the clearing pass.
  `MBS_ASSERT(a_restart_clears, s_axis_tvalid && s_axis_tready && s_axis_tuser |=> state_q == ST_CLEAR, "restart did not start the clearing pass")
  // A dead end with a non-empty stack pops exactly one entry.
  `MBS_ASSERT(a_backtrack_pops, state_q == ST_DECIDE && cand_q == '0 && count_q != '0 |=> state_q == ST_POP && count_q == $past(count_q) - CNT_W'(1), "backtrack did not pop one entry")
  // A carving decision always reports a carved wall.
  `MBS_ASSERT(a_carve_reported, state_q == ST_DECIDE && cand_q != '0 |=> res_q.carved && !res_q.finished, "carve not reported")
  // The stack never holds more entries than there are cells.
  `MBS_ASSERT_ALWAYS(a_stack_bound, count_q <= CNT_W'(CELL_COUNT), "stack count beyond capacity")

endmodule
